/* rtl/glyphcmp_pkg.sv */
// Shared types and constants of the glyph coverage compositor.
package glyphcmp_pkg;

	localparam int NUM_STAGES = 12;

	localparam logic [7:0]  FULL_COV      = 8'd255;
	localparam logic [7:0]  DARK_STRENGTH = 8'd192;
	localparam logic [7:0]  ROUND_HALF    = 8'd127;
	localparam logic [15:0] BOOST_DIV     = 16'd65025;
	localparam logic [23:0] CONTRAST_DIV  = 24'd16581375;
	localparam logic [8:0]  RECIP_255     = 9'd257;

	localparam logic [1:0] CURVE_NORMAL = 2'd0;
	localparam logic [1:0] CURVE_LIGHT  = 2'd1;
	localparam logic [1:0] CURVE_DARK   = 2'd2;

	localparam logic [2:0] CFG_CURVE_MODE       = 3'd0;
	localparam logic [2:0] CFG_STEM_GAIN        = 3'd1;
	localparam logic [2:0] CFG_CONTRAST_GAIN    = 3'd2;
	localparam logic [2:0] CFG_FOREGROUND_COLOR = 3'd3;
	localparam logic [2:0] CFG_BACKGROUND_COLOR = 3'd4;
	localparam logic [2:0] CFG_SOLID_PAPER      = 3'd5;

	typedef struct packed {
		logic [1:0]  curve_mode;
		logic [7:0]  stem_gain;
		logic [7:0]  contrast_gain;
		logic [15:0] foreground_color;
		logic [15:0] background_color;
		logic        solid_paper;
	} cfg_t;

endpackage

/* rtl/glyphcmp_pipe_ctrl.sv */
// Valid bits and per-stage advance enables of the compositor pipeline.
module glyphcmp_pipe_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [glyphcmp_pkg::NUM_STAGES-1:0] en
);

	logic [glyphcmp_pkg::NUM_STAGES-1:0] valid_q;

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		en[glyphcmp_pkg::NUM_STAGES-1] = !valid_q[glyphcmp_pkg::NUM_STAGES-1] || !out_stall;
		for (int i = glyphcmp_pkg::NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < glyphcmp_pkg::NUM_STAGES; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = valid_q[glyphcmp_pkg::NUM_STAGES-1];

endmodule

/* rtl/glyphcmp_shape.sv */
// Coverage pre-shaping: light contrast S-curve and dark fixed boost, stages 1 to 5.
module glyphcmp_shape (
	input  logic                clk,
	input  logic [4:0]          en,
	input  glyphcmp_pkg::cfg_t  cfg,
	input  logic [7:0]          coverage_in,
	input  logic [15:0]         dest_pixel,
	output logic [7:0]          a_s5,
	output logic [7:0]          t_s5,
	output logic [15:0]         dest_s5
);

	logic [7:0]  a_s1, a_s2, a_s3, a_s4;
	logic [15:0] dest_s1, dest_s2, dest_s3, dest_s4;
	logic        cneg_s1, cneg_s2, cneg_s3, cneg_s4;
	logic [13:0] prod_s1;
	logic [7:0]  cmag_s1;
	logic [21:0] lightx_s2, darky_s2;
	logic [29:0] lightxs_s3;
	logic [5:0]  dq0_s3;
	logic [16:0] drem_s3;
	logic [5:0]  cq0_s4;
	logic [24:0] crem_s4;
	logic [7:0]  dark_t_s4;

	logic [15:0] prod_full;
	logic [5:0]  dq0;
	logic [21:0] drem_full;
	logic [5:0]  cq0;
	logic [29:0] crem_full;
	logic [6:0]  dq;
	logic [8:0]  dsum;
	logic [5:0]  cq;
	logic [8:0]  lsum;
	logic [7:0]  light_t;
	logic [7:0]  t_sel;

	always_comb begin
		prod_full = 16'(coverage_in) * 16'(glyphcmp_pkg::FULL_COV - coverage_in);
		dq0       = darky_s2[21:16];
		drem_full = darky_s2 - 22'(dq0) * 22'(glyphcmp_pkg::BOOST_DIV);
		cq0       = lightxs_s3[29:24];
		crem_full = lightxs_s3 - 30'(cq0) * 30'(glyphcmp_pkg::CONTRAST_DIV);
		dq        = 7'(dq0_s3) + 7'(drem_s3 >= 17'(glyphcmp_pkg::BOOST_DIV));
		dsum      = 9'(a_s3) + 9'(dq);
		cq        = cq0_s4 + 6'(crem_s4 >= 25'(glyphcmp_pkg::CONTRAST_DIV));
		lsum      = 9'(a_s4) + 9'(cq);
		if (cneg_s4) begin
			light_t = (8'(cq) > a_s4) ? 8'd0 : a_s4 - 8'(cq);
		end else begin
			light_t = lsum[8] ? glyphcmp_pkg::FULL_COV : lsum[7:0];
		end
		unique case (cfg.curve_mode)
			glyphcmp_pkg::CURVE_LIGHT: t_sel = light_t;
			glyphcmp_pkg::CURVE_DARK:  t_sel = dark_t_s4;
			default:                   t_sel = a_s4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1    <= coverage_in;
			dest_s1 <= dest_pixel;
			prod_s1 <= prod_full[13:0];
			// Magnitude of 2a-255 is always odd, so its low bit is one.
			cmag_s1 <= {coverage_in[7] ? coverage_in[6:0] : ~coverage_in[6:0], 1'b1};
			cneg_s1 <= !coverage_in[7];
		end
		if (en[1]) begin
			a_s2      <= a_s1;
			dest_s2   <= dest_s1;
			cneg_s2   <= cneg_s1;
			lightx_s2 <= 22'(prod_s1) * 22'(cmag_s1);
			darky_s2  <= 22'(prod_s1) * 22'(glyphcmp_pkg::DARK_STRENGTH);
		end
		if (en[2]) begin
			a_s3       <= a_s2;
			dest_s3    <= dest_s2;
			cneg_s3    <= cneg_s2;
			lightxs_s3 <= 30'(lightx_s2) * 30'(cfg.contrast_gain);
			dq0_s3     <= dq0;
			drem_s3    <= drem_full[16:0];
		end
		if (en[3]) begin
			a_s4      <= a_s3;
			dest_s4   <= dest_s3;
			cneg_s4   <= cneg_s3;
			cq0_s4    <= cq0;
			crem_s4   <= crem_full[24:0];
			dark_t_s4 <= dsum[8] ? glyphcmp_pkg::FULL_COV : dsum[7:0];
		end
		if (en[4]) begin
			a_s5    <= a_s4;
			dest_s5 <= dest_s4;
			t_s5    <= t_sel;
		end
	end

endmodule

/* rtl/glyphcmp_boost.sv */
// Midtone boost by stem darkening strength and endpoint handling, stages 6 to 9.
module glyphcmp_boost (
	input  logic                clk,
	input  logic [3:0]          en,
	input  glyphcmp_pkg::cfg_t  cfg,
	input  logic [7:0]          a_s5,
	input  logic [7:0]          t_s5,
	input  logic [15:0]         dest_s5,
	output logic [7:0]          c_s9,
	output logic [15:0]         dest_s9
);

	logic [7:0]  a_s6, a_s7, a_s8;
	logic [7:0]  t_s6, t_s7, t_s8;
	logic [15:0] dest_s6, dest_s7, dest_s8;
	logic [13:0] bprod_s6;
	logic [21:0] bx_s7;
	logic [5:0]  bq0_s8;
	logic [16:0] brem_s8;

	logic [15:0] bprod_full;
	logic [5:0]  bq0;
	logic [21:0] brem_full;
	logic [6:0]  bq;
	logic [8:0]  bsum;
	logic [7:0]  c_next;

	always_comb begin
		bprod_full = 16'(t_s5) * 16'(glyphcmp_pkg::FULL_COV - t_s5);
		bq0        = bx_s7[21:16];
		brem_full  = bx_s7 - 22'(bq0) * 22'(glyphcmp_pkg::BOOST_DIV);
		bq         = 7'(bq0_s8) + 7'(brem_s8 >= 17'(glyphcmp_pkg::BOOST_DIV));
		bsum       = 9'(t_s8) + 9'(bq);
		priority if (a_s8 == 8'd0) begin
			c_next = 8'd0;
		end else if (a_s8 == glyphcmp_pkg::FULL_COV || bsum[8]) begin
			c_next = glyphcmp_pkg::FULL_COV;
		end else begin
			c_next = bsum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s6     <= a_s5;
			t_s6     <= t_s5;
			dest_s6  <= dest_s5;
			bprod_s6 <= bprod_full[13:0];
		end
		if (en[1]) begin
			a_s7    <= a_s6;
			t_s7    <= t_s6;
			dest_s7 <= dest_s6;
			bx_s7   <= 22'(bprod_s6) * 22'(cfg.stem_gain);
		end
		if (en[2]) begin
			a_s8    <= a_s7;
			t_s8    <= t_s7;
			dest_s8 <= dest_s7;
			bq0_s8  <= bq0;
			brem_s8 <= brem_full[16:0];
		end
		if (en[3]) begin
			c_s9    <= c_next;
			dest_s9 <= dest_s8;
		end
	end

endmodule

/* rtl/glyphcmp_blend.sv */
// RGB565 channel blend with rounding division by 255, stages 10 to 12.
module glyphcmp_blend (
	input  logic                clk,
	input  logic [2:0]          en,
	input  glyphcmp_pkg::cfg_t  cfg,
	input  logic [7:0]          c_s9,
	input  logic [15:0]         dest_s9,
	output logic [15:0]         pixel_out,
	output logic                write_enable
);

	function automatic logic [13:0] mix_sum(input logic [5:0] d, input logic [5:0] f,
			input logic [7:0] c);
		return 14'(d) * 14'(glyphcmp_pkg::FULL_COV - c) + 14'(f) * 14'(c)
			+ 14'(glyphcmp_pkg::ROUND_HALF);
	endfunction

	function automatic logic [5:0] quot_est(input logic [13:0] v);
		logic [22:0] p;
		p = 23'(v) * 23'(glyphcmp_pkg::RECIP_255);
		return p[21:16];
	endfunction

	function automatic logic [8:0] rem_est(input logic [13:0] v, input logic [5:0] q);
		logic [13:0] r;
		r = v - 14'(q) * 14'(glyphcmp_pkg::FULL_COV);
		return r[8:0];
	endfunction

	function automatic logic [5:0] quot_fix(input logic [5:0] q, input logic [8:0] r);
		return q + 6'(r >= 9'(glyphcmp_pkg::FULL_COV));
	endfunction

	logic [15:0] base;
	logic [13:0] vr_s10, vg_s10, vb_s10;
	logic [7:0]  c_s10, c_s11;
	logic [5:0]  qr_s11, qg_s11, qb_s11;
	logic [8:0]  rr_s11, rg_s11, rb_s11;
	logic [5:0]  r_fix, g_fix, b_fix;

	always_comb begin
		base  = cfg.solid_paper ? cfg.background_color : dest_s9;
		r_fix = quot_fix(qr_s11, rr_s11);
		g_fix = quot_fix(qg_s11, rg_s11);
		b_fix = quot_fix(qb_s11, rb_s11);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s10  <= c_s9;
			vr_s10 <= mix_sum({1'b0, base[15:11]}, {1'b0, cfg.foreground_color[15:11]}, c_s9);
			vg_s10 <= mix_sum(base[10:5], cfg.foreground_color[10:5], c_s9);
			vb_s10 <= mix_sum({1'b0, base[4:0]}, {1'b0, cfg.foreground_color[4:0]}, c_s9);
		end
		if (en[1]) begin
			c_s11  <= c_s10;
			qr_s11 <= quot_est(vr_s10);
			qg_s11 <= quot_est(vg_s10);
			qb_s11 <= quot_est(vb_s10);
			rr_s11 <= rem_est(vr_s10, quot_est(vr_s10));
			rg_s11 <= rem_est(vg_s10, quot_est(vg_s10));
			rb_s11 <= rem_est(vb_s10, quot_est(vb_s10));
		end
		if (en[2]) begin
			write_enable <= (c_s11 != 8'd0);
			priority if (c_s11 == 8'd0) begin
				pixel_out <= 16'd0;
			end else if (c_s11 == glyphcmp_pkg::FULL_COV) begin
				pixel_out <= cfg.foreground_color;
			end else begin
				pixel_out <= {r_fix[4:0], g_fix, b_fix[4:0]};
			end
		end
	end

endmodule

/* rtl/glyph_coverage_rgb565_compositor_core.sv */
// Top level of the glyph coverage compositor: configuration registers and pipeline.
//
// Each input word carries an 8-bit glyph coverage and the current RGB565
// destination pixel; each output word carries the pixel to store and a write
// enable that is low where the reshaped coverage is zero.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The configuration port writes one register per cycle with
// cfg_we, cfg_index and cfg_wdata, and is only to be written while the pipeline
// holds no word; the block itself does not enforce this.
// The pipeline has 12 stages: out_valid rises once the accepted word reaches
// the last stage. Throughput is one word per cycle while the receiver does not
// stall; every stage holds a short multiply-add or one step of a division by a
// constant.
// When the receiver stalls, words pack into empty stages and the input side
// stalls only once all 12 stages are full.
// Reset clears the configuration registers and all valid bits; there is no
// clearing pass, and the block accepts input as soon as reset is released.
module glyph_coverage_rgb565_compositor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  coverage_in,
	input  logic [15:0] dest_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_out,
	output logic        write_enable,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	glyphcmp_pkg::cfg_t cfg_q;
	logic [glyphcmp_pkg::NUM_STAGES-1:0] en;
	logic [7:0]  a_s5, t_s5, c_s9;
	logic [15:0] dest_s5, dest_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				glyphcmp_pkg::CFG_CURVE_MODE:       cfg_q.curve_mode <= cfg_wdata[1:0];
				glyphcmp_pkg::CFG_STEM_GAIN:        cfg_q.stem_gain <= cfg_wdata[7:0];
				glyphcmp_pkg::CFG_CONTRAST_GAIN:    cfg_q.contrast_gain <= cfg_wdata[7:0];
				glyphcmp_pkg::CFG_FOREGROUND_COLOR: cfg_q.foreground_color <= cfg_wdata;
				glyphcmp_pkg::CFG_BACKGROUND_COLOR: cfg_q.background_color <= cfg_wdata;
				glyphcmp_pkg::CFG_SOLID_PAPER:      cfg_q.solid_paper <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	glyphcmp_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	glyphcmp_shape u_shape (
		.clk         (clk),
		.en          (en[4:0]),
		.cfg         (cfg_q),
		.coverage_in (coverage_in),
		.dest_pixel  (dest_pixel),
		.a_s5        (a_s5),
		.t_s5        (t_s5),
		.dest_s5     (dest_s5)
	);

	glyphcmp_boost u_boost (
		.clk     (clk),
		.en      (en[8:5]),
		.cfg     (cfg_q),
		.a_s5    (a_s5),
		.t_s5    (t_s5),
		.dest_s5 (dest_s5),
		.c_s9    (c_s9),
		.dest_s9 (dest_s9)
	);

	glyphcmp_blend u_blend (
		.clk          (clk),
		.en           (en[11:9]),
		.cfg          (cfg_q),
		.c_s9         (c_s9),
		.dest_s9      (dest_s9),
		.pixel_out    (pixel_out),
		.write_enable (write_enable)
	);

endmodule

/* rtl/glyphcmp_checker.sv */
// Port-level assertions for the compositor core and their bind.
module glyphcmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] pixel_out,
	input logic        write_enable
);

	// A held output word keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(write_enable))
		else $error("output word changed while stalled");

	// An unwritten pixel is reported as zero.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> pixel_out == 16'd0)
		else $error("pixel_out nonzero with write_enable low");

	// The input side stalls only when the pipeline is full behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");

endmodule

bind glyph_coverage_rgb565_compositor_core glyphcmp_checker u_checker (.*);
